[rtl/capsule_mesh_generator_top_assert.svh]
// ============================================================================
// Capsule mesh generator assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ============================================================================
`ifndef CAPSULE_MESH_GENERATOR_TOP_ASSERT_SVH
`define CAPSULE_MESH_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define CMG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define CMG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/cmg_pkg.sv]
// ============================================================================
// cmg_pkg
// Shared types, widths and the CORDIC arctangent table of the capsule mesh
// generator.
// ============================================================================
`timescale 1ns / 1ps

package cmg_pkg;

    // Mesh size limits; register and divider widths below are sized for them
    localparam int MAX_SEGMENTS = 64;
    localparam int MAX_RINGS    = 32;

    localparam int NUM_W       = 13;  // element number
    localparam int SEG_W       = 7;   // segments register
    localparam int RING_W      = 6;   // ring count register
    localparam int LEN_W       = 16;  // Q8.8 lengths
    localparam int CNT_W       = 16;  // vertex and triangle counts
    localparam int CORNER_W    = 12;
    localparam int PX_W        = 17;
    localparam int PY_W        = 18;
    localparam int TRIG_W      = 17;  // clamped Q1.15 sin/cos
    localparam int CX_W        = 18;  // CORDIC x/y working width
    localparam int ANG_W       = 32;  // angle in 2^-32 turn
    localparam int DIV_STEPS   = 7;
    localparam int DIV_STAGES  = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int FRAC_STEPS  = 8;
    localparam int FRAC_STAGES = ANG_W / FRAC_STEPS;
    localparam int CORDIC_PER  = 2;   // CORDIC iterations per stage
    localparam int CORDIC_X0   = 19898;
    localparam int PROD_W      = 34;
    localparam int WIDE_W      = 51;
    localparam int CFG_IDX_W   = 2;
    localparam int TDATA_W     = 88;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENTS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_COUNT  = 2'd3;

    typedef enum logic [2:0] {
        KIND_NONE,      // number past the count
        KIND_POLE_TOP,
        KIND_POLE_BOT,
        KIND_RING,      // vertex on a hemisphere ring
        KIND_FAN,       // triangle of a pole fan
        KIND_BAND       // triangle of a quad band
    } kind_t;

    // Mesh shape, clamped and derived from the registers
    typedef struct packed {
        logic [SEG_W-1:0]  seg;
        logic [RING_W-1:0] ring;
        logic [CNT_W-1:0]  rows;
        logic [CNT_W-1:0]  verts;
        logic [CNT_W-1:0]  tris;
        logic [CNT_W-1:0]  band_tris;
        logic [LEN_W-1:0]  radius;
        logic [LEN_W-1:0]  half_height;
    } shape_t;

    // One request as it moves down the pipeline
    typedef struct packed {
        logic                        valid;
        kind_t                       kind;
        logic                        oor;
        logic                        bottom;
        logic                        odd;
        logic [NUM_W-1:0]            dvd;
        logic [NUM_W-1:0]            quo;
        logic [SEG_W:0]              drem;
        logic [1:0][8:0]             frem;
        logic [1:0][ANG_W-1:0]       fq;
        logic [1:0][CX_W-1:0]        cx;
        logic [1:0][CX_W-1:0]        cy;
        logic [1:0][ANG_W-1:0]       cz;
        logic [1:0][1:0]             quad;
        logic [TRIG_W-1:0]           ct;
        logic [TRIG_W-1:0]           st;
        logic [TRIG_W-1:0]           cp;
        logic [TRIG_W-1:0]           sp;
        logic [PROD_W-1:0]           psc;
        logic [PROD_W-1:0]           pss;
        logic [PROD_W-1:0]           prc;
        logic [WIDE_W-1:0]           pxw;
        logic [WIDE_W-1:0]           pzw;
        logic [PY_W-1:0]             yw;
        logic [PX_W-1:0]             px;
        logic [PY_W-1:0]             py;
        logic [PX_W-1:0]             pz;
        logic [CORNER_W-1:0]         ca;
        logic [CORNER_W-1:0]         cb;
        logic [CORNER_W-1:0]         cc;
    } pipe_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [ANG_W-1:0] atan_turn(input int unsigned i);
        logic [ANG_W-1:0] a;
        case (i)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2FA;
            15: a = 32'h0000517D;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A30;
            19: a = 32'h00000518;
            20: a = 32'h0000028C;
            21: a = 32'h00000146;
            22: a = 32'h000000A3;
            23: a = 32'h00000051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

[rtl/cmg_index.sv]
// ============================================================================
// cmg_index
// Request decode, pipelined ring/segment divider and triangle corner build.
// ============================================================================
`timescale 1ns / 1ps

module cmg_index
    import cmg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  shape_t           shape,
    input  logic             in_valid,
    input  logic             in_action,
    input  logic [NUM_W-1:0] in_num,
    output pipe_t            out_item
);

    pipe_t dec_reg, dec_next;
    pipe_t dv_reg  [DIV_STAGES];
    pipe_t dv_next [DIV_STAGES];
    pipe_t ix_reg, ix_next;

    // Decode: classify the number, build fan corners, pick the dividend
    always_comb begin
        logic [CNT_W-1:0] n, seg16, k, u, sb, sb1, base;
        n     = CNT_W'(in_num);
        seg16 = CNT_W'(shape.seg);
        k     = n - 16'd1;
        u     = n - seg16;
        sb    = u - shape.band_tris;
        sb1   = sb + 16'd1;
        base  = shape.verts - 16'd1 - seg16;
        dec_next       = '0;
        dec_next.valid = in_valid;
        dec_next.kind  = KIND_NONE;
        if (!in_action) begin
            if (n >= shape.verts) begin
                dec_next.oor = 1'b1;
            end else if (n == '0) begin
                dec_next.kind = KIND_POLE_TOP;
            end else if (n == shape.verts - 16'd1) begin
                dec_next.kind = KIND_POLE_BOT;
            end else begin
                dec_next.kind   = KIND_RING;
                dec_next.bottom = (k >= shape.rows);
                dec_next.dvd    = NUM_W'((k >= shape.rows) ? k - shape.rows : k);
            end
        end else begin
            if (n >= shape.tris) begin
                dec_next.oor = 1'b1;
            end else if (n < seg16) begin
                // top fan around the pole
                dec_next.kind = KIND_FAN;
                dec_next.cb   = CORNER_W'(n + 16'd1);
                dec_next.cc   = (n + 16'd1 == seg16) ? CORNER_W'(1) : CORNER_W'(n + 16'd2);
            end else if (u < shape.band_tris) begin
                dec_next.kind = KIND_BAND;
                dec_next.dvd  = NUM_W'(u >> 1);
                dec_next.odd  = u[0];
            end else begin
                // bottom fan
                dec_next.kind = KIND_FAN;
                dec_next.ca   = CORNER_W'(shape.verts - 16'd1);
                dec_next.cb   = CORNER_W'(base + ((sb1 == seg16) ? 16'd0 : sb1));
                dec_next.cc   = CORNER_W'(base + sb);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_reg.valid <= 1'b0;
        end else if (adv) begin
            dec_reg <= dec_next;
        end
    end

    // Restoring division by the segment count, up to seven bits per stage
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        pipe_t src;
        if (j == 0) begin : g_first
            assign src = dec_reg;
        end else begin : g_rest
            assign src = dv_reg[j-1];
        end

        always_comb begin
            logic [SEG_W:0] r;
            dv_next[j] = src;
            r = src.drem;
            for (int t = 0; t < DIV_STEPS; t++) begin
                if (j * DIV_STEPS + t < NUM_W) begin
                    r = {r[SEG_W-1:0], dv_next[j].dvd[NUM_W-1]};
                    dv_next[j].dvd = dv_next[j].dvd << 1;
                    if (r >= {1'b0, shape.seg}) begin
                        r = r - {1'b0, shape.seg};
                        dv_next[j].quo = {dv_next[j].quo[NUM_W-2:0], 1'b1};
                    end else begin
                        dv_next[j].quo = {dv_next[j].quo[NUM_W-2:0], 1'b0};
                    end
                end
            end
            dv_next[j].drem = r;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[j].valid <= 1'b0;
            end else if (adv) begin
                dv_reg[j] <= dv_next[j];
            end
        end
    end

    // Ring/segment indexes for vertices, corner numbers for band triangles
    always_comb begin
        pipe_t               src;
        logic [SEG_W-1:0]    s, sn;
        logic [RING_W-1:0]   r6;
        logic [19:0]         prod;
        logic [CORNER_W-1:0] base, cur, nxt, curb, nxtb;
        src  = dv_reg[DIV_STAGES-1];
        s    = src.drem[SEG_W-1:0];
        sn   = (s + 7'd1 == shape.seg) ? '0 : s + 7'd1;
        r6   = src.bottom ? shape.ring - 6'd1 - src.quo[RING_W-1:0]
                          : src.quo[RING_W-1:0] + 6'd1;
        prod = {7'b0, src.quo} * {13'b0, shape.seg};
        base = prod[CORNER_W-1:0];
        cur  = base + CORNER_W'(s) + 12'd1;
        nxt  = base + CORNER_W'(sn) + 12'd1;
        curb = cur + CORNER_W'(shape.seg);
        nxtb = nxt + CORNER_W'(shape.seg);
        ix_next = src;
        ix_next.frem[0] = 9'(r6);
        ix_next.frem[1] = 9'(s);
        ix_next.fq      = '0;
        if (src.kind == KIND_BAND) begin
            if (!src.odd) begin
                ix_next.ca = cur;
                ix_next.cb = curb;
                ix_next.cc = nxtb;
            end else begin
                ix_next.ca = nxtb;
                ix_next.cb = nxt;
                ix_next.cc = cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ix_reg.valid <= 1'b0;
        end else if (adv) begin
            ix_reg <= ix_next;
        end
    end

    assign out_item = ix_reg;

endmodule

[rtl/cmg_frac.sv]
// ============================================================================
// cmg_frac
// Pipelined fraction divider: ring and segment angles as 32-bit turn counts.
// ============================================================================
`timescale 1ns / 1ps

module cmg_frac
    import cmg_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   adv,
    input  shape_t shape,
    input  pipe_t  in_item,
    output pipe_t  out_item
);

    pipe_t fr_reg  [FRAC_STAGES];
    pipe_t fr_next [FRAC_STAGES];

    // theta = r / (4 * rings) turn, phi = s / segments turn
    for (genvar j = 0; j < FRAC_STAGES; j++) begin : g_stage
        pipe_t src;
        if (j == 0) begin : g_first
            assign src = in_item;
        end else begin : g_rest
            assign src = fr_reg[j-1];
        end

        always_comb begin
            logic [1:0][7:0] den;
            logic [8:0]      r;
            den[0] = {shape.ring, 2'b00};
            den[1] = {1'b0, shape.seg};
            fr_next[j] = src;
            for (int l = 0; l < 2; l++) begin
                r = src.frem[l];
                for (int t = 0; t < FRAC_STEPS; t++) begin
                    r = {r[7:0], 1'b0};
                    if (r >= {1'b0, den[l]}) begin
                        r = r - {1'b0, den[l]};
                        fr_next[j].fq[l] = {fr_next[j].fq[l][ANG_W-2:0], 1'b1};
                    end else begin
                        fr_next[j].fq[l] = {fr_next[j].fq[l][ANG_W-2:0], 1'b0};
                    end
                end
                fr_next[j].frem[l] = r;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                fr_reg[j].valid <= 1'b0;
            end else if (adv) begin
                fr_reg[j] <= fr_next[j];
            end
        end
    end

    assign out_item = fr_reg[FRAC_STAGES-1];

endmodule

[rtl/cmg_cordic.sv]
// ============================================================================
// cmg_cordic
// Two-lane pipelined rotation CORDIC giving Q1.15 cos/sin of theta and phi.
// ============================================================================
`timescale 1ns / 1ps

module cmg_cordic
    import cmg_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  adv,
    input  pipe_t in_item,
    output pipe_t out_item
);

    localparam int NSTAGE = (CORDIC_STEPS + CORDIC_PER - 1) / CORDIC_PER;

    pipe_t cr_reg  [NSTAGE];
    pipe_t cr_next [NSTAGE];
    pipe_t fin_reg, fin_next;

    for (genvar j = 0; j < NSTAGE; j++) begin : g_stage
        pipe_t src;
        if (j == 0) begin : g_first
            // seed: quadrant from the top angle bits, residue into z
            always_comb begin
                src = in_item;
                for (int l = 0; l < 2; l++) begin
                    src.cx[l]   = CX_W'(CORDIC_X0);
                    src.cy[l]   = '0;
                    src.cz[l]   = {2'b00, in_item.fq[l][ANG_W-3:0]};
                    src.quad[l] = in_item.fq[l][ANG_W-1:ANG_W-2];
                end
            end
        end else begin : g_rest
            assign src = cr_reg[j-1];
        end

        always_comb begin
            logic signed [CX_W-1:0]  x, y, dx, dy;
            logic signed [ANG_W-1:0] z;
            cr_next[j] = src;
            for (int l = 0; l < 2; l++) begin
                x = $signed(src.cx[l]);
                y = $signed(src.cy[l]);
                z = $signed(src.cz[l]);
                for (int t = 0; t < CORDIC_PER; t++) begin
                    if (j * CORDIC_PER + t < CORDIC_STEPS) begin
                        dx = y >>> (j * CORDIC_PER + t);
                        dy = x >>> (j * CORDIC_PER + t);
                        if (!z[ANG_W-1]) begin
                            x = x - dx;
                            y = y + dy;
                            z = z - $signed(atan_turn(j * CORDIC_PER + t));
                        end else begin
                            x = x + dx;
                            y = y - dy;
                            z = z + $signed(atan_turn(j * CORDIC_PER + t));
                        end
                    end
                end
                cr_next[j].cx[l] = x;
                cr_next[j].cy[l] = y;
                cr_next[j].cz[l] = z;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cr_reg[j].valid <= 1'b0;
            end else if (adv) begin
                cr_reg[j] <= cr_next[j];
            end
        end
    end

    // Clamp to +-1.0 and fold the quadrant back in
    always_comb begin
        pipe_t                     src;
        logic signed [CX_W-1:0]    x, y;
        logic signed [TRIG_W-1:0]  xc, yc;
        logic [1:0][TRIG_W-1:0]    co, si;
        src = cr_reg[NSTAGE-1];
        for (int l = 0; l < 2; l++) begin
            x  = $signed(src.cx[l]);
            y  = $signed(src.cy[l]);
            xc = (x > 18'sd32768) ? 17'sd32768 :
                 (x < -18'sd32768) ? -17'sd32768 : x[TRIG_W-1:0];
            yc = (y > 18'sd32768) ? 17'sd32768 :
                 (y < -18'sd32768) ? -17'sd32768 : y[TRIG_W-1:0];
            case (src.quad[l])
                2'd0: begin co[l] = xc;  si[l] = yc;  end
                2'd1: begin co[l] = -yc; si[l] = xc;  end
                2'd2: begin co[l] = -xc; si[l] = -yc; end
                default: begin co[l] = yc; si[l] = -xc; end
            endcase
        end
        fin_next    = src;
        fin_next.ct = co[0];
        fin_next.st = si[0];
        fin_next.cp = co[1];
        fin_next.sp = si[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_reg.valid <= 1'b0;
        end else if (adv) begin
            fin_reg <= fin_next;
        end
    end

    assign out_item = fin_reg;

endmodule

[rtl/cmg_scale.sv]
// ============================================================================
// cmg_scale
// Scales sin/cos by radius, rounds to Q8.8 and forms the result fields.
// ============================================================================
`timescale 1ns / 1ps

module cmg_scale
    import cmg_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   adv,
    input  shape_t shape,
    input  pipe_t  in_item,
    output pipe_t  out_item
);

    pipe_t ma_reg, ma_next;
    pipe_t mb_reg, mb_next;
    pipe_t res_reg, res_next;

    // First products: sin(th)*cos(ph), sin(th)*sin(ph), radius*cos(th)
    always_comb begin
        ma_next     = in_item;
        ma_next.psc = $signed(in_item.st) * $signed(in_item.cp);
        ma_next.pss = $signed(in_item.st) * $signed(in_item.sp);
        ma_next.prc = $signed({1'b0, shape.radius}) * $signed(in_item.ct);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ma_reg.valid <= 1'b0;
        end else if (adv) begin
            ma_reg <= ma_next;
        end
    end

    // Radius times the trig products; y rounded and offset
    always_comb begin
        logic signed [PROD_W-1:0] yr;
        yr = ($signed(ma_reg.prc) + 34'sd16384) >>> 15;
        mb_next     = ma_reg;
        mb_next.pxw = $signed({1'b0, shape.radius}) * $signed(ma_reg.psc);
        mb_next.pzw = $signed({1'b0, shape.radius}) * $signed(ma_reg.pss);
        mb_next.yw  = yr[PY_W-1:0] + {2'b00, shape.half_height};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mb_reg.valid <= 1'b0;
        end else if (adv) begin
            mb_reg <= mb_next;
        end
    end

    // Round x/z, mirror bottom rows, select fields by kind
    always_comb begin
        logic signed [WIDE_W-1:0] xr, zr;
        logic [PY_W-1:0]          pole;
        xr   = ($signed(mb_reg.pxw) + 51'sd536870912) >>> 30;
        zr   = ($signed(mb_reg.pzw) + 51'sd536870912) >>> 30;
        pole = {2'b00, shape.half_height} + {2'b00, shape.radius};
        res_next    = mb_reg;
        res_next.px = '0;
        res_next.py = '0;
        res_next.pz = '0;
        case (mb_reg.kind)
            KIND_POLE_TOP: res_next.py = pole;
            KIND_POLE_BOT: res_next.py = -pole;
            KIND_RING: begin
                res_next.px = xr[PX_W-1:0];
                res_next.pz = zr[PX_W-1:0];
                res_next.py = mb_reg.bottom ? -mb_reg.yw : mb_reg.yw;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg.valid <= 1'b0;
        end else if (adv) begin
            res_reg <= res_next;
        end
    end

    assign out_item = res_reg;

endmodule

[rtl/capsule_mesh_generator_top.sv]
// ============================================================================
// capsule_mesh_generator_top
// Capsule mesh tessellator: vertex positions and triangle corners on request.
// ============================================================================
// Each request is independent and enters a fully pipelined datapath, so one
// request is taken per clock and one result leaves per clock unless the
// output stalls or a configuration write holds s_tready low. The stages are:
// decode, two divider stages, index build, four angle-fraction stages,
// the CORDIC at two iterations per stage plus a clamp stage, and three
// multiply/round stages ending in the output register. A stall on m_tready
// freezes every stage. After a configuration write, s_tready drops for one
// cycle while the derived mesh counts update.
`timescale 1ns / 1ps

module capsule_mesh_generator_top
    import cmg_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // requests
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [12:0] element_number
    input  logic                 s_tuser,   // [0] action
    // results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // pos_x, pos_y, pos_z, corner_a/b/c
    output logic                 m_tuser,   // [0] out_of_range
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data
);

    logic [LEN_W-1:0]  radius_reg, half_height_reg;
    logic [SEG_W-1:0]  segments_reg;
    logic [RING_W-1:0] rings_reg;
    logic              cfg_hold_reg;
    shape_t            shape_reg, shape_next;
    logic              adv;
    pipe_t             ix_item, fr_item, cr_item, out_item;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg      <= 16'd256;
            half_height_reg <= 16'd256;
            segments_reg    <= 7'd16;
            rings_reg       <= 6'd8;
            cfg_hold_reg    <= 1'b0;
        end else begin
            cfg_hold_reg <= cfg_valid;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_RADIUS:      radius_reg      <= cfg_data;
                    CFG_HALF_HEIGHT: half_height_reg <= cfg_data;
                    CFG_SEGMENTS:    segments_reg    <= cfg_data[SEG_W-1:0];
                    CFG_RING_COUNT:  rings_reg       <= cfg_data[RING_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Clamp and derive the mesh counts
    always_comb begin
        logic [SEG_W-1:0]  s;
        logic [RING_W-1:0] r;
        s = (segments_reg < 7'd3) ? 7'd3 :
            (int'(segments_reg) > MAX_SEGMENTS) ? SEG_W'(MAX_SEGMENTS) : segments_reg;
        r = (rings_reg < 6'd2) ? 6'd2 :
            (int'(rings_reg) > MAX_RINGS) ? RING_W'(MAX_RINGS) : rings_reg;
        shape_next.seg         = s;
        shape_next.ring        = r;
        shape_next.rows        = CNT_W'(r - 6'd1) * CNT_W'(s);
        shape_next.verts       = 16'd2 + (shape_next.rows << 1);
        shape_next.tris        = CNT_W'(s) * (CNT_W'(r) * 16'd4 - 16'd4);
        shape_next.band_tris   = CNT_W'(s) * (CNT_W'(r) * 16'd4 - 16'd6);
        shape_next.radius      = radius_reg;
        shape_next.half_height = half_height_reg;
    end

    always_ff @(posedge aclk) begin
        shape_reg <= shape_next;
    end

    // Whole pipeline moves unless the output register is held
    assign adv      = !out_item.valid || m_tready;
    assign s_tready = adv && !cfg_hold_reg;

    cmg_index u_index (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .shape     (shape_reg),
        .in_valid  (s_tvalid && s_tready),
        .in_action (s_tuser),
        .in_num    (s_tdata[NUM_W-1:0]),
        .out_item  (ix_item)
    );

    cmg_frac u_frac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .shape    (shape_reg),
        .in_item  (ix_item),
        .out_item (fr_item)
    );

    cmg_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_item  (fr_item),
        .out_item (cr_item)
    );

    cmg_scale u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .shape    (shape_reg),
        .in_item  (cr_item),
        .out_item (out_item)
    );

    assign m_tvalid = out_item.valid;
    assign m_tuser  = out_item.oor;
    assign m_tdata  = {out_item.cc, out_item.cb, out_item.ca,
                       out_item.pz, out_item.py, out_item.px};

`include "capsule_mesh_generator_top_assert.svh"

    `CMG_ASSERT_NOW(a_oor_zero, m_tvalid && m_tuser, m_tdata == '0, "out-of-range result carries data")
    `CMG_ASSERT_NOW(a_tri_no_pos, m_tvalid && (m_tdata[87:52] != '0), m_tdata[51:0] == '0, "triangle result carries a position")
    `CMG_ASSERT_NOW(a_stall_back, m_tvalid && !m_tready, !s_tready, "request taken during output stall")
    `CMG_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

endmodule
